[design/hashed_timing_wheel_core_defines.svh]
// Assertion macros for the hashed timing wheel core.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef HASHED_TIMING_WHEEL_CORE_DEFINES_SVH
`define HASHED_TIMING_WHEEL_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising clock edge while reset is released.
`define HTW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("htw check failed");
// Checked on every rising clock edge, reset included.
`define HTW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("htw check failed");
`else
`define HTW_ASSERT(lbl, clk, rstn, prop)
`define HTW_ASSERT_NR(lbl, clk, prop)
`endif

`endif

[design/htw_pkg.sv]
// Shared types and constants for the hashed timing wheel core.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package htw_pkg;

  // Table and wheel geometry. SLOTS must stay a power of two.
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned TIMERS    = 64;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ROUNDS_W  = 10;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned IVAL_W    = 16;
  localparam int unsigned DIV_STEPS = TMO_W;
  localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;
  localparam logic [IVAL_W-1:0]   IVAL_RESET = IVAL_W'(5);

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_ADJUST = 2'd1,
    FN_DELETE = 2'd2,
    FN_TICK   = 2'd3
  } htw_func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG     = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_ID  = 2'd3
  } htw_status_e;

  typedef struct packed {
    htw_func_e          func;
    logic [IDX_W-1:0]   timer_id;
    logic signed [TMO_W-1:0] timeout;
  } htw_in_t;

  typedef struct packed {
    htw_status_e        status;
    logic [IDX_W-1:0]   result_id;
    logic               expired;
    logic               last;
  } htw_out_t;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [ROUNDS_W-1:0] rounds;
  } htw_entry_t;

endpackage

[design/hashed_timing_wheel_core.sv]
// Hashed timing wheel core: sequencer, divider, valid bits and entry RAM.
// Depends on htw_pkg, htw_ram and hashed_timing_wheel_core_defines.svh.
`timescale 1ns / 1ps
//
// Usage
//   An operation enters on the in channel (valid/ready) as one htw_in_t transfer;
//   results leave on the out channel (valid/ready) as htw_out_t transfers, the
//   final one of each operation flagged by last. The block takes one operation
//   at a time; in_ready_o is high only while the sequencer is idle.
//   Delete goes from idle straight to its result. Adjust runs a 16-step restoring
//   divider by the tick interval. Add first walks the valid bits one entry a
//   cycle to find the lowest free entry, then divides. A tick walks all 64
//   entries, skipping free ones and reading each used one from the RAM before
//   checking it, then finishes in a last state that advances the wheel. The
//   index counter is shared by the find walk, the divider and the tick scan.
//   Expiries come out in ascending entry order. One expiry is held back until
//   the next is found, so that last can be set on the final one.
//   When the receiver stalls, the output register holds its transfer and the
//   sequencer waits at its next result. Reset clears all valid bits, the current
//   slot and the output valid flag, and sets the tick interval to 5. The
//   interval register must be written by cfg_we_i only while the block is idle;
//   the block itself does not enforce it.
module hashed_timing_wheel_core
  import htw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IVAL_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  htw_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output htw_out_t           out_data_o
);

`include "hashed_timing_wheel_core_defines.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIND  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_PLACE = 8'b0000_1000,
    S_RESP  = 8'b0001_0000,
    S_TRD   = 8'b0010_0000,
    S_TCHK  = 8'b0100_0000,
    S_TEND  = 8'b1000_0000
  } htw_state_e;

  htw_state_e          state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    tgt_q, tgt_d;
  logic [TIMERS-1:0]   valid_q, valid_d;
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic [IVAL_W-1:0]   ival_q;
  logic [TMO_W-1:0]    rem_q, rem_d;
  logic [TMO_W-1:0]    quo_q, quo_d;
  htw_status_e         res_st_q, res_st_d;
  logic [IDX_W-1:0]    res_id_q, res_id_d;
  logic                pend_v_q, pend_v_d;
  logic [IDX_W-1:0]    pend_id_q, pend_id_d;
  logic                out_valid_q, out_valid_d;
  htw_out_t            out_q, out_d;

  logic                can_push;
  logic                push;
  logic                cnt_last;
  logic                in_fire;
  logic                tmo_neg;
  logic                id_ok;

  // Divider datapath.
  logic [IVAL_W-1:0]   ival_eff;
  logic [TMO_W:0]      rem_sh;
  logic [TMO_W+1:0]    diff;

  // Placement datapath.
  logic [TMO_W-1:0]    ticks;
  logic [TMO_W-1:0]    rounds_full;
  htw_entry_t          new_entry;

  // Entry RAM ports.
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  htw_entry_t          ram_wdata, ram_rdata;

  htw_ram #(
    .Width($bits(htw_entry_t)),
    .Depth(TIMERS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_push    = ~out_valid_q | out_ready_i;
  assign cnt_last    = (cnt_q == IDX_W'(TIMERS - 1));
  assign tmo_neg     = in_data_i.timeout[TMO_W-1];
  assign id_ok       = ({1'b0, in_data_i.timer_id} < (IDX_W + 1)'(TIMERS)) &&
                       valid_q[in_data_i.timer_id];

  // One restoring division step; a zero interval counts as one.
  assign ival_eff = (ival_q == '0) ? IVAL_W'(1) : ival_q;
  assign rem_sh   = {rem_q, quo_q[TMO_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, ival_eff};

  // Ticks, rounds and target slot from the quotient.
  assign ticks        = (quo_q == '0) ? TMO_W'(1) : quo_q;
  assign rounds_full  = ticks >> SLOT_W;
  assign new_entry.rounds = (rounds_full > TMO_W'(ROUNDS_MAX)) ? ROUNDS_MAX
                                                               : rounds_full[ROUNDS_W-1:0];
  assign new_entry.slot   = cur_q + ticks[SLOT_W-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    valid_d     = valid_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    push        = 1'b0;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = tgt_q;
    ram_wdata   = new_entry;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d    = '0;
          rem_d    = '0;
          quo_d    = {1'b0, in_data_i.timeout[TMO_W-2:0]};
          res_id_d = '0;
          pend_v_d = 1'b0;
          case (in_data_i.func)
            FN_ADD: begin
              if (tmo_neg) begin
                res_st_d = ST_NEG;
                state_d  = S_RESP;
              end else begin
                state_d  = S_FIND;
              end
            end
            FN_ADJUST: begin
              if (tmo_neg) begin
                res_st_d = ST_NEG;
                state_d  = S_RESP;
              end else if (!id_ok) begin
                res_st_d = ST_BAD_ID;
                state_d  = S_RESP;
              end else begin
                tgt_d    = in_data_i.timer_id;
                state_d  = S_DIV;
              end
            end
            FN_DELETE: begin
              if (!id_ok) begin
                res_st_d = ST_BAD_ID;
              end else begin
                res_st_d = ST_OK;
                res_id_d = in_data_i.timer_id;
                valid_d[in_data_i.timer_id] = 1'b0;
              end
              state_d = S_RESP;
            end
            FN_TICK: begin
              state_d = S_TRD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Walk the valid bits for the lowest free entry.
      S_FIND: begin
        if (!valid_q[cnt_q]) begin
          tgt_d   = cnt_q;
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (cnt_last) begin
          res_st_d = ST_FULL;
          state_d  = S_RESP;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      // One quotient bit a cycle.
      S_DIV: begin
        if (!diff[TMO_W+1]) begin
          rem_d = diff[TMO_W-1:0];
          quo_d = {quo_q[TMO_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[TMO_W-1:0];
          quo_d = {quo_q[TMO_W-2:0], 1'b0};
        end
        if (cnt_q == IDX_W'(DIV_STEPS - 1)) begin
          state_d = S_PLACE;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      // Store slot and rounds, mark the entry used.
      S_PLACE: begin
        ram_we         = 1'b1;
        valid_d[tgt_q] = 1'b1;
        res_st_d       = ST_OK;
        res_id_d       = tgt_q;
        state_d        = S_RESP;
      end

      // Single result of add, adjust or delete.
      S_RESP: begin
        if (can_push) begin
          push             = 1'b1;
          out_d.status     = res_st_q;
          out_d.result_id  = res_id_q;
          out_d.expired    = 1'b0;
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end

      // Tick scan: read used entries, skip free ones.
      S_TRD: begin
        if (valid_q[cnt_q]) begin
          ram_re  = 1'b1;
          state_d = S_TCHK;
        end else if (cnt_last) begin
          state_d = S_TEND;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      // Tick scan: count down or expire an entry in the current slot; pass over the rest.
      S_TCHK: begin
        if (ram_rdata.slot == cur_q && ram_rdata.rounds != '0) begin
          ram_we           = 1'b1;
          ram_waddr        = cnt_q;
          ram_wdata.slot   = ram_rdata.slot;
          ram_wdata.rounds = ram_rdata.rounds - ROUNDS_W'(1);
          cnt_d            = cnt_q + IDX_W'(1);
          state_d          = cnt_last ? S_TEND : S_TRD;
        end else if (ram_rdata.slot == cur_q) begin
          if (!pend_v_q || can_push) begin
            if (pend_v_q) begin
              push            = 1'b1;
              out_d.status    = ST_OK;
              out_d.result_id = pend_id_q;
              out_d.expired   = 1'b1;
              out_d.last      = 1'b0;
            end
            pend_v_d       = 1'b1;
            pend_id_d      = cnt_q;
            valid_d[cnt_q] = 1'b0;
            cnt_d          = cnt_q + IDX_W'(1);
            state_d        = cnt_last ? S_TEND : S_TRD;
          end
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = cnt_last ? S_TEND : S_TRD;
        end
      end

      // Final tick result, then advance the wheel.
      S_TEND: begin
        if (can_push) begin
          push            = 1'b1;
          out_d.status    = ST_OK;
          out_d.result_id = pend_v_q ? pend_id_q : '0;
          out_d.expired   = pend_v_q;
          out_d.last      = 1'b1;
          cur_d           = cur_q + SLOT_W'(1);
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      cur_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ival_q      <= IVAL_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      cur_q       <= cur_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ival_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    pend_id_q <= pend_id_d;
    if (push) begin
      out_q <= out_d;
    end
  end

  // Assertions.
  `HTW_ASSERT(a_scan_no_last, clk_i, rst_ni, (state_q == S_TCHK && push) |-> !out_d.last)
  `HTW_ASSERT(a_wheel_advance, clk_i, rst_ni,
              (state_q == S_TEND && can_push) |=> (cur_q == $past(cur_q) + SLOT_W'(1)))
  `HTW_ASSERT(a_place_marks_valid, clk_i, rst_ni, (state_q == S_PLACE) |=> valid_q[$past(tgt_q)])
  `HTW_ASSERT(a_expiry_ok, clk_i, rst_ni,
              (out_valid_o && out_data_o.expired) |-> (out_data_o.status == ST_OK))
  `HTW_ASSERT_NR(a_busy_no_accept, clk_i, (state_q != S_IDLE) |-> !in_ready_o)

endmodule

[design/htw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module htw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/tb_hashed_timing_wheel_core.sv]
// Self-checking testbench for the hashed timing wheel core.
// Depends on htw_pkg and hashed_timing_wheel_core; it keeps its own model of the wheel.
`timescale 1ns / 1ps

module tb_hashed_timing_wheel_core;
  import htw_pkg::*;

  localparam int unsigned RUN_LIMIT = 1_000_000;
  localparam int unsigned END_SETTLE = 140;
  localparam int unsigned CFG_SETTLE = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IVAL_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  htw_in_t            in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  htw_out_t           out_data_o;

  // Shadow copy of the wheel state, updated on every accepted transfer.
  bit                  wheel_live [TIMERS];
  logic [SLOT_W-1:0]   wheel_slot [TIMERS];
  logic [ROUNDS_W-1:0] wheel_rounds [TIMERS];
  logic [SLOT_W-1:0]   wheel_now;
  logic [IVAL_W-1:0]   wheel_interval;

  htw_out_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned run_cycles = 0;

  hashed_timing_wheel_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Queue one expected result transfer.
  function automatic void push_result(htw_status_e st, int unsigned id, bit exp, bit last);
    htw_out_t r;
    r.status    = st;
    r.result_id = IDX_W'(id);
    r.expired   = exp;
    r.last      = last;
    pending_results.push_back(r);
  endfunction

  // Convert a non-negative timeout into rounds and a target slot for one entry.
  function automatic void place_entry(int unsigned idx, logic [TMO_W-1:0] tmo);
    int unsigned iv;
    int unsigned ticks;
    int unsigned rounds;
    iv = (wheel_interval == '0) ? 1 : wheel_interval;
    ticks = (tmo < iv) ? 1 : tmo / iv;
    rounds = ticks / SLOTS;
    if (rounds > ROUNDS_MAX) begin
      rounds = ROUNDS_MAX;
    end
    wheel_rounds[idx] = ROUNDS_W'(rounds);
    wheel_slot[idx]   = SLOT_W'((wheel_now + ticks % SLOTS) % SLOTS);
  endfunction

  // Work out the result transfers of one operation and update the shadow state.
  function automatic void wheel_predict(htw_in_t op);
    int unsigned idx;
    int unsigned hits;
    bit          found;
    bit          neg;
    idx   = 0;
    hits  = 0;
    found = 1'b0;
    neg   = op.timeout[TMO_W-1];
    case (op.func)
      FN_ADD: begin
        if (neg) begin
          push_result(ST_NEG, 0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (!found && !wheel_live[i]) begin
              idx = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            push_result(ST_FULL, 0, 1'b0, 1'b1);
          end else begin
            wheel_live[idx] = 1'b1;
            place_entry(idx, op.timeout);
            push_result(ST_OK, idx, 1'b0, 1'b1);
          end
        end
      end
      FN_ADJUST: begin
        if (neg) begin
          push_result(ST_NEG, 0, 1'b0, 1'b1);
        end else if (!wheel_live[op.timer_id]) begin
          push_result(ST_BAD_ID, 0, 1'b0, 1'b1);
        end else begin
          place_entry(op.timer_id, op.timeout);
          push_result(ST_OK, op.timer_id, 1'b0, 1'b1);
        end
      end
      FN_DELETE: begin
        if (!wheel_live[op.timer_id]) begin
          push_result(ST_BAD_ID, 0, 1'b0, 1'b1);
        end else begin
          wheel_live[op.timer_id] = 1'b0;
          push_result(ST_OK, op.timer_id, 1'b0, 1'b1);
        end
      end
      default: begin
        // Scan the current slot in index order: count down or expire.
        for (int i = 0; i < TIMERS; i++) begin
          if (wheel_live[i] && wheel_slot[i] == wheel_now) begin
            if (wheel_rounds[i] != '0) begin
              wheel_rounds[i] = wheel_rounds[i] - 1'b1;
            end else begin
              wheel_live[i] = 1'b0;
              push_result(ST_OK, i, 1'b1, 1'b0);
              hits++;
            end
          end
        end
        wheel_now = wheel_now + 1'b1;
        if (hits == 0) begin
          push_result(ST_OK, 0, 1'b0, 1'b1);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic htw_in_t make_op(htw_func_e f, int unsigned id, logic [TMO_W-1:0] tmo);
    htw_in_t op;
    op.func     = f;
    op.timer_id = IDX_W'(id);
    op.timeout  = tmo;
    return op;
  endfunction

  function automatic int unsigned count_live();
    int unsigned n;
    n = 0;
    for (int i = 0; i < TIMERS; i++) begin
      n += wheel_live[i];
    end
    return n;
  endfunction

  // Mostly timeouts short enough to expire within the run, some of any value.
  function automatic logic [TMO_W-1:0] pick_timeout();
    int unsigned iv;
    int unsigned top;
    int unsigned r;
    iv = (wheel_interval == '0) ? 1 : wheel_interval;
    top = iv * 80;
    if (top > 32767) begin
      top = 32767;
    end
    r = $urandom_range(99);
    if (r < 10) begin
      return TMO_W'($urandom_range(65535));
    end else if (r < 25) begin
      return TMO_W'($urandom_range((iv - 1 > 32767) ? 32767 : iv - 1, 0));
    end
    return TMO_W'($urandom_range(top, 0));
  endfunction

  // Usually a live entry, otherwise any index.
  function automatic int unsigned pick_id();
    int unsigned start;
    start = $urandom_range(TIMERS - 1);
    if ($urandom_range(99) < 75) begin
      for (int k = 0; k < TIMERS; k++) begin
        if (wheel_live[(start + k) % TIMERS]) begin
          return (start + k) % TIMERS;
        end
      end
    end
    return start;
  endfunction

  // Send one operation; valid stays high across back-to-back transfers.
  task automatic send_op(htw_in_t op);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    wheel_predict(op);
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic wait_drained(int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [IVAL_W-1:0] value);
    wait_drained(CFG_SETTLE);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    wheel_interval = value;
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, every operation and the negative and bad-id error codes from reset state.
  task automatic test_basic_ops();
    send_idle_pct = 0;
    stall_pct = 0;
    send_op(make_op(FN_ADD, 0, 16'h8000));
    send_op(make_op(FN_ADD, 63, 16'h0000));
    send_op(make_op(FN_ADD, 0, 16'h7FFF));
    send_op(make_op(FN_ADD, 0, 16'd4));
    send_op(make_op(FN_ADD, 0, 16'd5));
    send_op(make_op(FN_ADJUST, 0, 16'hFFFF));
    send_op(make_op(FN_ADJUST, 63, 16'd10));
    send_op(make_op(FN_ADJUST, 1, 16'd10));
    send_op(make_op(FN_DELETE, 63, 16'h0000));
    send_op(make_op(FN_DELETE, 3, 16'h0000));
    send_op(make_op(FN_DELETE, 3, 16'hFFFF));
    send_op(make_op(FN_TICK, 63, 16'h7FFF));
    send_op(make_op(FN_TICK, 0, 16'h0000));
    send_op(make_op(FN_TICK, 0, 16'h0000));
    send_op(make_op(FN_ADJUST, 0, 16'd7));
    send_op(make_op(FN_DELETE, 0, 16'h0000));
  endtask

  // An interval of zero behaves as one timeout unit per tick.
  task automatic test_zero_interval();
    write_interval('0);
    send_op(make_op(FN_ADD, 0, 16'd1));
    send_op(make_op(FN_ADD, 0, 16'd0));
    send_op(make_op(FN_ADD, 0, 16'd2));
    send_op(make_op(FN_TICK, 0, 16'h0000));
    send_op(make_op(FN_TICK, 0, 16'h0000));
    send_op(make_op(FN_TICK, 0, 16'h0000));
  endtask

  // Fill the whole table, hit the full case, then tick until every entry expires.
  task automatic test_table_fill();
    write_interval(IVAL_RESET);
    send_idle_pct = 0;
    stall_pct = 20;
    while (count_live() < TIMERS) begin
      send_op(make_op(FN_ADD, $urandom_range(63), TMO_W'($urandom_range(315))));
    end
    repeat (3) send_op(make_op(FN_ADD, $urandom_range(63), TMO_W'($urandom_range(315))));
    send_op(make_op(FN_ADJUST, pick_id(), TMO_W'($urandom_range(315))));
    send_op(make_op(FN_DELETE, 37, 16'h0000));
    send_op(make_op(FN_ADD, 0, TMO_W'($urandom_range(315))));
    repeat (SLOTS) send_op(make_op(FN_TICK, $urandom_range(63), TMO_W'($urandom_range(65535))));
  endtask

  // Random mix of operations at one interval and one idling pattern.
  task automatic test_random_traffic(int unsigned n, logic [IVAL_W-1:0] iv,
                                     int unsigned idle, int unsigned stall);
    int unsigned r;
    htw_func_e   f;
    write_interval(iv);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        f = FN_ADD;
      end else if (r < 45) begin
        f = FN_ADJUST;
      end else if (r < 55) begin
        f = FN_DELETE;
      end else begin
        f = FN_TICK;
      end
      send_op(make_op(f, (f == FN_ADD || f == FN_TICK) ? $urandom_range(63) : pick_id(),
                      pick_timeout()));
    end
  endtask

  // Receiver backpressure follows the current stall percentage.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result transfer with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    htw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d id %0d expired %0b last %0b",
                   out_data_o.status, out_data_o.result_id, out_data_o.expired,
                   out_data_o.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.result_id !== want.result_id ||
            out_data_o.expired !== want.expired || out_data_o.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected status %0d id %0d expired %0b last %0b, got status %0d id %0d expired %0b last %0b",
                     want.status, want.result_id, want.expired, want.last,
                     out_data_o.status, out_data_o.result_id, out_data_o.expired,
                     out_data_o.last);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (run_cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      run_cycles++;
    end
    $display("hashed_timing_wheel_core regression: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < TIMERS; i++) begin
      wheel_live[i]   = 1'b0;
      wheel_slot[i]   = '0;
      wheel_rounds[i] = '0;
    end
    wheel_now      = '0;
    wheel_interval = IVAL_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_zero_interval();
    test_table_fill();
    test_random_traffic(45, 16'd1, 0, 0);
    test_random_traffic(45, 16'hFFFF, 63, 0);
    test_random_traffic(45, IVAL_W'($urandom_range(9, 2)), 0, 63);
    test_random_traffic(45, IVAL_W'($urandom_range(40, 1)), 38, 38);
    write_interval(IVAL_RESET);
    wait_drained(END_SETTLE);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("hashed_timing_wheel_core regression: pass");
    end else begin
      $display("hashed_timing_wheel_core regression: fail");
    end
    $finish;
  end

endmodule
